FILE: rtl/i2sbq_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the I2S sample gain and biquad filter.
package i2sbq_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int HALF_W    = 16;
  localparam int COEF_W    = 24;
  localparam int GAIN_W    = 4;
  localparam int X_W       = 20;
  localparam int Y_W       = 40;
  localparam int Y_FRAC_W  = 16;
  localparam int MUL_A_W   = COEF_W;
  localparam int MUL_B_W   = 25;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 68;
  localparam int CFG_IDX_W = 3;

  // Default number of fractional coefficient bits.
  localparam int COEF_FRAC_BITS_DEF = 22;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  // Reset values of the configuration registers.
  localparam logic signed [COEF_W-1:0] B0_RST   = 24'sd3405144;
  localparam logic signed [COEF_W-1:0] B1_RST   = 24'sd6810289;
  localparam logic signed [COEF_W-1:0] B2_RST   = 24'sd3405144;
  localparam logic signed [COEF_W-1:0] A1_RST   = -24'sd6662955;
  localparam logic signed [COEF_W-1:0] A2_RST   = -24'sd2763318;
  localparam logic [GAIN_W-1:0]        GAIN_RST = 4'd3;

  // Order of the products formed on the shared multiplier.
  typedef enum logic [2:0] {
    STEP_GAIN,
    STEP_B1,
    STEP_B2,
    STEP_A1H,
    STEP_A2H,
    STEP_A1L,
    STEP_A2L,
    STEP_B0
  } step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  mul_en;
    step_t step;
    logic  commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: rtl/i2sbq_ctrl.sv
`timescale 1ns / 1ps
// Controller that sequences the multiply steps of one sample.
module i2sbq_ctrl
  import i2sbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ACC,
    ST_DONE
  } state_t;

  state_t state;
  step_t  step;

  // State and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_GAIN;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= STEP_GAIN;
          if (s_tvalid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == STEP_B0) begin
            state <= ST_ACC;
          end else begin
            step <= step_t'(step + 3'd1);
          end
        end
        ST_ACC: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  assign s_tready   = (state == ST_IDLE);
  assign cmd.load   = s_tvalid && (state == ST_IDLE);
  assign cmd.mul_en = (state == ST_RUN);
  assign cmd.step   = step;
  assign cmd.commit = (state == ST_DONE) && status.out_free;

endmodule

FILE: rtl/i2sbq_datapath.sv
`timescale 1ns / 1ps
// Datapath: coefficient registers, shared multiplier, accumulator, delay line and output.
module i2sbq_datapath
  import i2sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic [2*HALF_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata,
  input  cmd_t                 cmd,
  output status_t              status
);

  logic signed [COEF_W-1:0]   coef_b0;
  logic signed [COEF_W-1:0]   coef_b1;
  logic signed [COEF_W-1:0]   coef_b2;
  logic signed [COEF_W-1:0]   coef_a1;
  logic signed [COEF_W-1:0]   coef_a2;
  logic [GAIN_W-1:0]          input_gain;

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [X_W-1:0]      x_cur;
  logic signed [X_W-1:0]      input_delay_one;
  logic signed [X_W-1:0]      input_delay_two;
  logic signed [Y_W-1:0]      output_delay_one;
  logic signed [Y_W-1:0]      output_delay_two;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_vld;
  step_t                      prod_step;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc;

  logic signed [ACC_W-1:0]    y_full;
  logic                       y_pos_ovf;
  logic                       y_neg_ovf;
  logic signed [Y_W-1:0]      y_sat;
  logic signed [Y_W-Y_FRAC_W:0] y_int;
  logic signed [SAMPLE_W-1:0] y_out;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0    <= B0_RST;
      coef_b1    <= B1_RST;
      coef_b2    <= B2_RST;
      coef_a1    <= A1_RST;
      coef_a2    <= A2_RST;
      input_gain <= GAIN_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_B0:   coef_b0    <= cfg_data;
        REG_B1:   coef_b1    <= cfg_data;
        REG_B2:   coef_b2    <= cfg_data;
        REG_A1:   coef_a1    <= cfg_data;
        REG_A2:   coef_a2    <= cfg_data;
        REG_GAIN: input_gain <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sample capture: high half bits 14..0 over bit 15 of the low half.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= {s_tdata[HALF_W-2:0], s_tdata[2*HALF_W-1]};
    end
  end

  // Operand selection for the shared multiplier. Past outputs are split
  // into a signed integer part and an unsigned 16-bit fraction.
  always_comb begin
    case (cmd.step)
      STEP_GAIN: begin
        mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, input_gain};
        mul_b = {{(MUL_B_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      end
      STEP_B1: begin
        mul_a = coef_b1;
        mul_b = {{(MUL_B_W-X_W){input_delay_one[X_W-1]}}, input_delay_one};
      end
      STEP_B2: begin
        mul_a = coef_b2;
        mul_b = {{(MUL_B_W-X_W){input_delay_two[X_W-1]}}, input_delay_two};
      end
      STEP_A1H: begin
        mul_a = coef_a1;
        mul_b = {output_delay_one[Y_W-1], output_delay_one[Y_W-1:Y_FRAC_W]};
      end
      STEP_A2H: begin
        mul_a = coef_a2;
        mul_b = {output_delay_two[Y_W-1], output_delay_two[Y_W-1:Y_FRAC_W]};
      end
      STEP_A1L: begin
        mul_a = coef_a1;
        mul_b = {{(MUL_B_W-Y_FRAC_W){1'b0}}, output_delay_one[Y_FRAC_W-1:0]};
      end
      STEP_A2L: begin
        mul_a = coef_a2;
        mul_b = {{(MUL_B_W-Y_FRAC_W){1'b0}}, output_delay_two[Y_FRAC_W-1:0]};
      end
      STEP_B0: begin
        mul_a = coef_b0;
        mul_b = {{(MUL_B_W-X_W){x_cur[X_W-1]}}, x_cur};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod      <= mul_a * mul_b;
      prod_step <= cmd.step;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Accumulate with 16 extra fractional bits; integer-part products are
  // scaled up by 2^16. The gain product becomes the current input x.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (prod_vld) begin
      case (prod_step)
        STEP_GAIN: x_cur <= prod[X_W-1:0];
        STEP_A1L, STEP_A2L: acc <= acc + prod_ext;
        default: acc <= acc + {prod_ext[ACC_W-Y_FRAC_W-1:0], {Y_FRAC_W{1'b0}}};
      endcase
    end
  end

  // Floor to 16 fractional bits and clamp to the 40-bit state range.
  assign y_full    = acc >>> COEF_FRAC_BITS;
  assign y_pos_ovf = !y_full[ACC_W-1] && (|y_full[ACC_W-2:Y_W-1]);
  assign y_neg_ovf = y_full[ACC_W-1] && !(&y_full[ACC_W-2:Y_W-1]);

  always_comb begin
    if (y_pos_ovf) begin
      y_sat = {1'b0, {(Y_W-1){1'b1}}};
    end else if (y_neg_ovf) begin
      y_sat = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_sat = y_full[Y_W-1:0];
    end
  end

  // Integer part truncated toward zero, then clamped to 16 bits.
  assign y_int = {y_sat[Y_W-1], y_sat[Y_W-1:Y_FRAC_W]}
               + {{(Y_W-Y_FRAC_W){1'b0}}, (y_sat[Y_W-1] && (|y_sat[Y_FRAC_W-1:0]))};

  always_comb begin
    if (!y_int[Y_W-Y_FRAC_W] && (|y_int[Y_W-Y_FRAC_W-1:SAMPLE_W-1])) begin
      y_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (y_int[Y_W-Y_FRAC_W] && !(&y_int[Y_W-Y_FRAC_W-1:SAMPLE_W-1])) begin
      y_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_out = y_int[SAMPLE_W-1:0];
    end
  end

  // Delay line update at the end of each sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_delay_one  <= '0;
      input_delay_two  <= '0;
      output_delay_one <= '0;
      output_delay_two <= '0;
    end else if (cmd.commit) begin
      input_delay_two  <= input_delay_one;
      input_delay_one  <= x_cur;
      output_delay_two <= output_delay_one;
      output_delay_one <= y_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= y_out;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

endmodule

FILE: rtl/i2s_sample_gain_biquad_filter_core.sv
`timescale 1ns / 1ps
// Top level of the I2S sample gain and direct-form-1 biquad filter.
// Each input beat carries one I2S slot; the block forms a 16-bit sample from
// high-half bits 14..0 and low-half bit 15, multiplies it by input_gain and
// runs it through one biquad with signed coefficients of COEF_FRAC_BITS
// fractional bits and past outputs kept with 16 fractional bits. One output
// beat follows each input beat: y truncated toward zero and saturated to
// int16. All products go through one shared 24x25 multiplier, eight per
// sample. After an input beat is accepted, the block runs the multiply steps,
// then an accumulate state, then a result state in which the result is
// written to the output register; it takes the next input beat once it has
// left the result state. If the previous result is still pending there, the
// block holds in its result state until the output register frees up. A
// finished result waits in the output register while the next sample is
// computed. Configuration registers should be written only while no sample
// is in flight, since the datapath reads them throughout a sample.
module i2s_sample_gain_biquad_filter_core
  import i2sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*HALF_W-1:0]  s_tdata,   // high_half [15:0], low_half [31:16]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata    // filtered_sample [15:0]
);

  cmd_t    cmd;
  status_t status;

  // Step sequencer.
  i2sbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  i2sbq_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // Once a beat is taken, the next one waits for the current sample.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a sample is in progress");

  // A result is written only into a free output register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending output beat");

  // A new output beat appears only at the end of a sample's work.
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("output beat raised while idle");
`endif

endmodule

FILE: sim/i2sbq_filter_monitor.sv
`timescale 1ns / 1ps
// Monitor that predicts and checks the filtered samples of the I2S biquad core.
module i2sbq_filter_monitor
  import i2sbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [2*HALF_W-1:0]  s_tdata,   // high_half [15:0], low_half [31:16]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [SAMPLE_W-1:0]  m_tdata,   // filtered_sample [15:0]
  output int                   errors,
  output int                   outstanding
);

  // Rails of the stored output and of the output sample.
  localparam longint Y_HI = (longint'(1) <<< (Y_W - 1)) - 1;
  localparam longint Y_LO = -(longint'(1) <<< (Y_W - 1));
  localparam longint S_HI = 32767;
  localparam longint S_LO = -32768;

  // Alignment of the sum to the 16 fractional bits of y.
  localparam int DROP_W  = (COEF_FRAC_BITS >= Y_FRAC_W) ? COEF_FRAC_BITS - Y_FRAC_W : 0;
  localparam int RAISE_W = (COEF_FRAC_BITS < Y_FRAC_W) ? Y_FRAC_W - COEF_FRAC_BITS : 0;
  localparam int LOW_W   = COEF_FRAC_BITS % Y_FRAC_W;

  // Local copy of the coefficients, the gain and the filter history.
  logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [X_W-1:0]      x_d1, x_d2;
  logic signed [Y_W-1:0]      y_d1, y_d2;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want;
  int                         mismatches = 0;

  assign errors = mismatches;

  // Runs one slot through the filter history and returns the output sample.
  function automatic logic signed [SAMPLE_W-1:0] biquad_predict(
    input logic [HALF_W-1:0] hi,
    input logic [HALF_W-1:0] lo
  );
    logic signed [SAMPLE_W-1:0] sample;
    longint x, yh1, yl1, yh2, yl2, hsum, lsum, lh, ll, t, y, ip;
    sample = {hi[14:0], lo[15]};
    x   = longint'(sample) * longint'(gain_q);
    yh1 = longint'(y_d1) >>> Y_FRAC_W;
    yl1 = longint'(y_d1) - (yh1 <<< Y_FRAC_W);
    yh2 = longint'(y_d2) >>> Y_FRAC_W;
    yl2 = longint'(y_d2) - (yh2 <<< Y_FRAC_W);
    // Integer parts of the past outputs and the inputs in one sum, fractions apart.
    hsum = longint'(b0_q) * x + longint'(b1_q) * longint'(x_d1)
         + longint'(b2_q) * longint'(x_d2)
         + longint'(a1_q) * yh1 + longint'(a2_q) * yh2;
    lsum = longint'(a1_q) * yl1 + longint'(a2_q) * yl2;
    lh   = lsum >>> Y_FRAC_W;
    ll   = lsum - (lh <<< Y_FRAC_W);
    t    = hsum + lh;
    if (RAISE_W == 0) begin
      y = t >>> DROP_W;
    end else begin
      y = (t <<< RAISE_W) + (ll >>> LOW_W);
    end
    if (y > Y_HI) y = Y_HI;
    if (y < Y_LO) y = Y_LO;
    x_d2 = x_d1;
    x_d1 = x[X_W-1:0];
    y_d2 = y_d1;
    y_d1 = y[Y_W-1:0];
    // Truncate toward zero, then clamp to int16.
    if (y >= 0) begin
      ip = y >>> Y_FRAC_W;
    end else begin
      ip = -((-y) >>> Y_FRAC_W);
    end
    if (ip > S_HI) ip = S_HI;
    if (ip < S_LO) ip = S_LO;
    return ip[SAMPLE_W-1:0];
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(
    input string                      what,
    input logic signed [SAMPLE_W-1:0] wanted,
    input logic signed [SAMPLE_W-1:0] got
  );
    $display("[%0t] %s: expected %0d, got %0d", $time, what, wanted, got);
    mismatches++;
  endtask

  // Follow configuration writes, compare output beats, predict input beats.
  always @(posedge clk) begin
    if (rst) begin
      b0_q   = B0_RST;
      b1_q   = B1_RST;
      b2_q   = B2_RST;
      a1_q   = A1_RST;
      a2_q   = A2_RST;
      gain_q = GAIN_RST;
      x_d1   = '0;
      x_d2   = '0;
      y_d1   = '0;
      y_d2   = '0;
      expected_samples.delete();
      outstanding <= 0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_B0:   b0_q   = cfg_data;
          REG_B1:   b1_q   = cfg_data;
          REG_B2:   b2_q   = cfg_data;
          REG_A1:   a1_q   = cfg_data;
          REG_A2:   a2_q   = cfg_data;
          REG_GAIN: gain_q = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("output beat with no sample pending", '0, m_tdata);
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want) begin
            report_mismatch("filtered_sample", want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_samples.push_back(biquad_predict(s_tdata[HALF_W-1:0],
                                                  s_tdata[2*HALF_W-1:HALF_W]));
      end
      outstanding <= expected_samples.size();
    end
  end

endmodule

FILE: sim/i2s_sample_gain_biquad_filter_core_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives slots and filter settings into the biquad core.
module i2s_sample_gain_biquad_filter_core_tb;
  import i2sbq_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int PHASE_ITEMS   = 300;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [COEF_W-1:0] COEF_MAX  = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 24'sh800000;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 24'sh000000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [2*HALF_W-1:0]  s_tdata;   // high_half [15:0], low_half [31:16]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SAMPLE_W-1:0]  m_tdata;   // filtered_sample [15:0]

  int                   errors;
  int                   outstanding;
  int                   send_idle_pct = 0;
  int                   rcv_idle_pct  = 0;
  int                   hold_req      = 0;
  int                   holds_done    = 0;
  int                   cycle_count   = 0;
  int                   pick;
  logic [HALF_W-1:0]    hi, lo;

  i2s_sample_gain_biquad_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  i2sbq_filter_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Clock of 8 ns.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random back-pressure, plus long holds on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Coefficient within a quarter of the full range.
  function automatic logic signed [COEF_W-1:0] mild_coef();
    return COEF_W'(int'($urandom_range(0, 4194303)) - 2097152);
  endfunction

  // Offers one slot, with a random gap ahead of it, and waits for the beat.
  task automatic send_slot(input logic [HALF_W-1:0] high_half, input logic [HALF_W-1:0] low_half);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {low_half, high_half};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every pending sample has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers back to back, then the two unused indexes.
  task automatic program_filter(
    input logic signed [COEF_W-1:0] b0,
    input logic signed [COEF_W-1:0] b1,
    input logic signed [COEF_W-1:0] b2,
    input logic signed [COEF_W-1:0] a1,
    input logic signed [COEF_W-1:0] a2,
    input logic [GAIN_W-1:0]        gain
  );
    logic [CFG_IDX_W-1:0] idx [8];
    logic [COEF_W-1:0]    val [8];
    idx = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_GAIN, REG_SPARE_LO, REG_SPARE_HI};
    val = '{b0, b1, b2, a1, a2, {20'($urandom), gain}, 24'($urandom), 24'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_en    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_en <= 1'b0;
  endtask

  // Reset, directed slots, then random phases under changing settings.
  initial begin
    rst       = 1'b1;
    cfg_en    = 1'b0;
    cfg_index = REG_B0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset filter: zero, both sample rails into output saturation, odd bits.
    send_slot(16'h0000, 16'h0000);
    repeat (3) send_slot(16'h3FFF, 16'h8000);
    repeat (3) send_slot(16'h4000, 16'h0000);
    send_slot(16'hFFFF, 16'hFFFF);
    send_slot(16'h8000, 16'h7FFF);
    send_slot(16'h0000, 16'h8000);
    drain_results();

    // Largest coefficients and gain drive the stored output into its rails.
    program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 4'd15);
    repeat (4) send_slot(16'h3FFF, 16'h8000);
    repeat (3) send_slot(16'h4000, 16'h0000);
    drain_results();

    // Smallest coefficients with zero gain: only the feedback is left.
    program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 4'd0);
    repeat (2) send_slot(16'h3FFF, 16'h8000);
    send_slot(16'h4000, 16'h0000);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_filter(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST, GAIN_RST);
        1: program_filter(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef(),
                          4'($urandom));
        2: program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, 4'd15);
        3: program_filter(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 4'($urandom));
        4: program_filter(mild_coef(), mild_coef(), mild_coef(), COEF_ZERO, COEF_ZERO, 4'd1);
        default: program_filter(mild_coef(), mild_coef(), mild_coef(), mild_coef(),
                                mild_coef(), 4'($urandom));
      endcase
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 63 : 0;
      rcv_idle_pct  = (ph < 2) ? 63 : (ph < 4) ? 8 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long output stall while slots keep coming, and one full pause.
        if (ph == 4 && n == 100) hold_req++;
        if (ph == 2 && n == 150) drain_results();
        hi   = 16'($urandom);
        lo   = 16'($urandom);
        pick = $urandom_range(9);
        case (pick)
          0: begin
            hi = {hi[15], 1'b0, 14'h3FFF};
            lo[15] = 1'b1;
          end
          1: begin
            hi = {hi[15], 1'b1, 14'h0000};
            lo[15] = 1'b0;
          end
          default: ;
        endcase
        send_slot(hi, lo);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: i2s_sample_gain_biquad_filter_core.f
rtl/i2sbq_pkg.sv
rtl/i2sbq_ctrl.sv
rtl/i2sbq_datapath.sv
rtl/i2s_sample_gain_biquad_filter_core.sv
sim/i2sbq_filter_monitor.sv
sim/i2s_sample_gain_biquad_filter_core_tb.sv
